// ===== design/lfu_pkg.sv =====
// shared types and constants for the lfu cache table
package lfu_pkg;

  localparam int unsigned ENTRIES_DEF    = 16;
  localparam int unsigned KEY_BITS_DEF   = 32;
  localparam int unsigned VALUE_BITS_DEF = 32;
  localparam int unsigned COUNT_BITS_DEF = 16;

  localparam int unsigned CAP_BITS = 5;
  localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

  typedef enum logic {
    OP_GET = 1'b0,
    OP_PUT = 1'b1
  } lfu_op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_RANK,
    ST_COMMIT,
    ST_RESULT
  } lfu_state_t;

  typedef struct packed {
    logic capture;
    logic scan_key;
    logic decide;
    logic scan_rank;
    logic commit;
    logic load_out;
  } lfu_cmd_t;

  typedef struct packed {
    logic pass_done;
    logic out_free;
  } lfu_sts_t;

endpackage

// ===== design/lfu_req_if.sv =====
// request channel of the lfu cache table
interface lfu_req_if #(
  parameter int unsigned KEY_BITS   = lfu_pkg::KEY_BITS_DEF,
  parameter int unsigned VALUE_BITS = lfu_pkg::VALUE_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic                  opcode;
  logic [KEY_BITS-1:0]   key;
  logic [VALUE_BITS-1:0] value;

  modport source (output valid, opcode, key, value, input ready);
  modport sink   (input valid, opcode, key, value, output ready);
endinterface

// ===== design/lfu_rsp_if.sv =====
// result channel of the lfu cache table
interface lfu_rsp_if #(
  parameter int unsigned KEY_BITS   = lfu_pkg::KEY_BITS_DEF,
  parameter int unsigned VALUE_BITS = lfu_pkg::VALUE_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic                  hit;
  logic [VALUE_BITS-1:0] read_value;
  logic                  evicted;
  logic [KEY_BITS-1:0]   evicted_key;

  modport source (output valid, hit, read_value, evicted, evicted_key, input ready);
  modport sink   (input valid, hit, read_value, evicted, evicted_key, output ready);
endinterface

// ===== design/lfu_cache_table_core.sv =====
// top level of the lfu cache table: one request in, one result out per request
// sequence: request capture, key/victim scan pass over the entry memories, replacement decision,
// recency rank update pass, commit, then the result register load once that register is free
// a new request is taken only in idle, after the last result is loaded; it is taken while a result waits
// reset: synchronous active-low rst_n empties the table and sets capacity to 16; no clearing pass
module lfu_cache_table_core #(
  parameter int unsigned ENTRIES    = lfu_pkg::ENTRIES_DEF,
  parameter int unsigned KEY_BITS   = lfu_pkg::KEY_BITS_DEF,
  parameter int unsigned VALUE_BITS = lfu_pkg::VALUE_BITS_DEF,
  parameter int unsigned COUNT_BITS = lfu_pkg::COUNT_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [lfu_pkg::CAP_BITS-1:0] cfg_wdata,
  lfu_req_if.sink                      in_req,
  lfu_rsp_if.source                    out_rsp
);
  import lfu_pkg::*;

  lfu_cmd_t cmd;
  lfu_sts_t sts;

  lfu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_req.valid),
    .req_ready (in_req.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  lfu_dp #(
    .ENTRIES    (ENTRIES),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .cmd             (cmd),
    .sts             (sts),
    .req_opcode      (in_req.opcode),
    .req_key         (in_req.key),
    .req_value       (in_req.value),
    .out_ready       (out_rsp.ready),
    .out_valid       (out_rsp.valid),
    .out_hit         (out_rsp.hit),
    .out_read_value  (out_rsp.read_value),
    .out_evicted     (out_rsp.evicted),
    .out_evicted_key (out_rsp.evicted_key)
  );

endmodule

// ===== design/lfu_ctrl.sv =====
// controller state machine sequencing the scan, rank and commit phases
module lfu_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              req_valid,
  output logic              req_ready,
  input  lfu_pkg::lfu_sts_t sts,
  output lfu_pkg::lfu_cmd_t cmd
);
  import lfu_pkg::*;

  lfu_state_t state_r;
  lfu_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (req_valid) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (sts.pass_done) state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        state_nxt = ST_RANK;
      end
      ST_RANK: begin
        if (sts.pass_done) state_nxt = ST_COMMIT;
      end
      ST_COMMIT: begin
        state_nxt = ST_RESULT;
      end
      ST_RESULT: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd       = '0;
    req_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        req_ready   = 1'b1;
        cmd.capture = req_valid;
      end
      ST_SCAN:   cmd.scan_key  = 1'b1;
      ST_DECIDE: cmd.decide    = 1'b1;
      ST_RANK:   cmd.scan_rank = 1'b1;
      ST_COMMIT: cmd.commit    = 1'b1;
      ST_RESULT: cmd.load_out  = sts.out_free;
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ===== design/lfu_dp.sv =====
// datapath: entry memories, scan compare, victim search, rank update and result register
module lfu_dp #(
  parameter int unsigned ENTRIES    = lfu_pkg::ENTRIES_DEF,
  parameter int unsigned KEY_BITS   = lfu_pkg::KEY_BITS_DEF,
  parameter int unsigned VALUE_BITS = lfu_pkg::VALUE_BITS_DEF,
  parameter int unsigned COUNT_BITS = lfu_pkg::COUNT_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [lfu_pkg::CAP_BITS-1:0] cfg_wdata,
  input  lfu_pkg::lfu_cmd_t            cmd,
  output lfu_pkg::lfu_sts_t            sts,
  input  logic                         req_opcode,
  input  logic [KEY_BITS-1:0]          req_key,
  input  logic [VALUE_BITS-1:0]        req_value,
  input  logic                         out_ready,
  output logic                         out_valid,
  output logic                         out_hit,
  output logic [VALUE_BITS-1:0]        out_read_value,
  output logic                         out_evicted,
  output logic [KEY_BITS-1:0]          out_evicted_key
);
  import lfu_pkg::*;

  localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(ENTRIES + 1);
  localparam int unsigned CW    = (CNT_W > CAP_BITS) ? CNT_W : CAP_BITS;
  localparam logic [CNT_W-1:0]      ENT_CNT = CNT_W'(ENTRIES);
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
  localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);

  // entry storage
  logic [KEY_BITS-1:0]   key_mem  [ENTRIES];
  logic [VALUE_BITS-1:0] val_mem  [ENTRIES];
  logic [COUNT_BITS-1:0] cnt_mem  [ENTRIES];
  logic [IDX_W-1:0]      rank_mem [ENTRIES];
  logic [ENTRIES-1:0]    valid_r;
  logic [CNT_W-1:0]      occ_r;
  logic [CAP_BITS-1:0]   cap_r;

  // captured request
  lfu_op_t               op_r;
  logic [KEY_BITS-1:0]   key_r;
  logic [VALUE_BITS-1:0] wval_r;

  // scan pipeline
  logic [CNT_W-1:0]      rd_cnt_r;
  logic                  pv_r;
  logic [IDX_W-1:0]      idx_q_r;
  logic                  vld_q_r;
  logic [KEY_BITS-1:0]   key_q_r;
  logic [COUNT_BITS-1:0] cnt_q_r;
  logic [IDX_W-1:0]      rank_q_r;
  logic [VALUE_BITS-1:0] rdval_q_r;

  // scan results
  logic                  found_r;
  logic [IDX_W-1:0]      found_idx_r;
  logic [COUNT_BITS-1:0] found_cnt_r;
  logic [IDX_W-1:0]      found_rank_r;
  logic                  vic_r;
  logic [IDX_W-1:0]      vic_idx_r;
  logic [COUNT_BITS-1:0] vic_cnt_r;
  logic [IDX_W-1:0]      vic_rank_r;
  logic [KEY_BITS-1:0]   vic_key_r;
  logic                  free_r;
  logic [IDX_W-1:0]      free_idx_r;

  // plan
  logic                  pl_hit_r;
  logic                  pl_evict_r;
  logic                  pl_insert_r;
  logic [IDX_W-1:0]      pl_target_r;
  logic [IDX_W-1:0]      pl_piv_r;

  // result register
  logic                  out_valid_r;
  logic                  out_hit_r;
  logic [VALUE_BITS-1:0] out_read_value_r;
  logic                  out_evicted_r;
  logic [KEY_BITS-1:0]   out_evicted_key_r;

  logic                  scanning;
  logic                  issue;
  logic [IDX_W-1:0]      rd_idx;
  logic                  cand_better;
  logic [CW-1:0]         cap_eff;
  logic [CW-1:0]         occ_w;
  logic [CW-1:0]         occ_after;
  logic                  d_hit;
  logic                  d_mput;
  logic                  d_evict;
  logic                  d_insert;
  logic [IDX_W-1:0]      d_slot;
  logic                  rp_we;
  logic                  r_inc;
  logic                  r_dec;
  logic [IDX_W-1:0]      rank_new;
  logic [COUNT_BITS-1:0] cnt_commit;

  assign scanning = cmd.scan_key || cmd.scan_rank;
  assign issue    = scanning && (rd_cnt_r < ENT_CNT);
  assign rd_idx   = rd_cnt_r[IDX_W-1:0];

  assign sts.pass_done = (rd_cnt_r == ENT_CNT) && !pv_r;
  assign sts.out_free  = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_we) begin
      cap_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r   <= lfu_op_t'(req_opcode);
      key_r  <= req_key;
      wval_r <= req_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_cnt_r <= '0;
      pv_r     <= 1'b0;
    end else if (cmd.capture || cmd.decide) begin
      rd_cnt_r <= '0;
      pv_r     <= 1'b0;
    end else if (scanning) begin
      if (issue) rd_cnt_r <= rd_cnt_r + CNT_W'(1);
      pv_r <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      idx_q_r  <= rd_idx;
      vld_q_r  <= valid_r[rd_idx];
      key_q_r  <= key_mem[rd_idx];
      cnt_q_r  <= cnt_mem[rd_idx];
      rank_q_r <= rank_mem[rd_idx];
    end
    rdval_q_r <= val_mem[found_idx_r];
  end

  assign cand_better = !vic_r || (cnt_q_r < vic_cnt_r) ||
                       ((cnt_q_r == vic_cnt_r) && (rank_q_r > vic_rank_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
      vic_r   <= 1'b0;
      free_r  <= 1'b0;
    end else if (cmd.capture) begin
      found_r <= 1'b0;
      vic_r   <= 1'b0;
      free_r  <= 1'b0;
    end else if (cmd.scan_key && pv_r) begin
      if (vld_q_r && (key_q_r == key_r) && !found_r) begin
        found_r      <= 1'b1;
        found_idx_r  <= idx_q_r;
        found_cnt_r  <= cnt_q_r;
        found_rank_r <= rank_q_r;
      end
      if (vld_q_r && cand_better) begin
        vic_r      <= 1'b1;
        vic_idx_r  <= idx_q_r;
        vic_cnt_r  <= cnt_q_r;
        vic_rank_r <= rank_q_r;
        vic_key_r  <= key_q_r;
      end
      if (!vld_q_r && !free_r) begin
        free_r     <= 1'b1;
        free_idx_r <= idx_q_r;
      end
    end
  end

  // replacement decision
  assign cap_eff   = (CW'(cap_r) > CW'(ENTRIES)) ? CW'(ENTRIES) : CW'(cap_r);
  assign occ_w     = CW'(occ_r);
  assign d_hit     = (cap_eff != '0) && found_r;
  assign d_mput    = (cap_eff != '0) && !found_r && (op_r == OP_PUT);
  assign d_evict   = d_mput && (occ_w >= cap_eff) && vic_r;
  assign occ_after = occ_w - CW'(d_evict);
  assign d_insert  = d_mput && (occ_after < cap_eff) && (free_r || d_evict);
  assign d_slot    = (d_evict && (!free_r || (vic_idx_r < free_idx_r))) ? vic_idx_r
                                                                         : free_idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pl_hit_r    <= 1'b0;
      pl_evict_r  <= 1'b0;
      pl_insert_r <= 1'b0;
      pl_target_r <= '0;
      pl_piv_r    <= '0;
    end else if (cmd.decide) begin
      pl_hit_r    <= d_hit;
      pl_evict_r  <= d_evict;
      pl_insert_r <= d_insert;
      pl_target_r <= d_hit ? found_idx_r : d_slot;
      pl_piv_r    <= d_hit ? found_rank_r : vic_rank_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      occ_r   <= '0;
    end else if (cmd.decide && d_evict) begin
      valid_r[vic_idx_r] <= 1'b0;
      occ_r              <= occ_r - CNT_W'(1);
    end else if (cmd.commit && pl_insert_r) begin
      valid_r[pl_target_r] <= 1'b1;
      occ_r                <= occ_r + CNT_W'(1);
    end
  end

  // rank pass: age newer entries on a touch, close the gap of a victim, age all on insert
  assign rp_we    = cmd.scan_rank && pv_r && vld_q_r;
  assign r_inc    = (pl_hit_r && (rank_q_r < pl_piv_r)) || pl_insert_r;
  assign r_dec    = pl_evict_r && (rank_q_r > pl_piv_r);
  assign rank_new = rank_q_r + IDX_W'(r_inc) - IDX_W'(r_dec);

  always_ff @(posedge clk) begin
    if (cmd.commit && (pl_hit_r || pl_insert_r)) begin
      rank_mem[pl_target_r] <= '0;
    end else if (rp_we) begin
      rank_mem[idx_q_r] <= rank_new;
    end
  end

  assign cnt_commit = pl_insert_r ? CNT_ONE :
                      (found_cnt_r == CNT_MAX) ? found_cnt_r : found_cnt_r + CNT_ONE;

  always_ff @(posedge clk) begin
    if (cmd.commit && (pl_hit_r || pl_insert_r)) begin
      cnt_mem[pl_target_r] <= cnt_commit;
    end
    if (cmd.commit && pl_insert_r) begin
      key_mem[pl_target_r] <= key_r;
    end
    if (cmd.commit && (pl_insert_r || (pl_hit_r && (op_r == OP_PUT)))) begin
      val_mem[pl_target_r] <= wval_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_hit_r         <= pl_hit_r;
      out_read_value_r  <= (pl_hit_r && (op_r == OP_GET)) ? rdval_q_r : '0;
      out_evicted_r     <= pl_evict_r;
      out_evicted_key_r <= pl_evict_r ? vic_key_r : '0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_hit         = out_hit_r;
  assign out_read_value  = out_read_value_r;
  assign out_evicted     = out_evicted_r;
  assign out_evicted_key = out_evicted_key_r;

  a_occ_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_r) == int'(occ_r))
    else $error("occupancy count differs from number of valid entries");

  a_evict_not_hit: assert property (@(posedge clk) disable iff (!rst_n)
    pl_evict_r |-> !pl_hit_r)
    else $error("eviction planned on a hit");

  a_insert_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && pl_insert_r) |-> !valid_r[pl_target_r])
    else $error("insert into an occupied entry");

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_ready))
    else $error("result register overwritten before it was taken");

endmodule
